// ===== sv/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by spq_cell, sorted_priority_queue_unit, spq_checker and tb.
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int DATA_BITS_DEF     = 16;
    localparam int PRIORITY_BITS_DEF = 8;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic [1:0] t_status;

    localparam t_status ST_PUSHED = 2'd0;
    localparam t_status ST_POPPED = 2'd1;
    localparam t_status ST_EMPTY  = 2'd2;
    localparam t_status ST_FULL   = 2'd3;

    // Broadcast to every cell; at most one is set in a cycle
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

// ===== sv/sorted_priority_queue_unit.sv =====
// Sorted priority queue: a chain of compare-and-shift cells, head at cell 0.
// The result strobe rises in the cycle after start is taken.
// Throughput: one push or pop per cycle; each cell settles its slot in a single
// compare and shift, so busy stays low.
// Reset (i_rst_n low, synchronous) empties the queue and clears the strobe;
// slot contents are left as they are. Results cannot be stalled.
module sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int DATA_BITS     = spq_pkg::DATA_BITS_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int CNT_BITS      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_operation,
    input  logic [DATA_BITS-1:0]     i_item_data,
    input  logic [PRIORITY_BITS-1:0] i_item_priority,
    output logic                     o_result_valid,
    output spq_pkg::t_status         o_status,
    output logic [DATA_BITS-1:0]     o_out_data,
    output logic [PRIORITY_BITS-1:0] o_out_priority,
    output logic [CNT_BITS-1:0]      o_occupancy
);
    import spq_pkg::*;

    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);

    logic [CNT_BITS-1:0]      r_count;
    logic [CNT_BITS-1:0]      n_count;
    logic                     r_result_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic [DATA_BITS-1:0]     r_out_data;
    logic [DATA_BITS-1:0]     n_out_data;
    logic [PRIORITY_BITS-1:0] r_out_prio;
    logic [PRIORITY_BITS-1:0] n_out_prio;

    logic                     take;
    logic                     is_full;
    logic                     is_empty;
    t_cell_ctrl               ctrl;

    logic                     w_keep [QUEUE_DEPTH];
    logic [DATA_BITS-1:0]     w_data [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_prio [QUEUE_DEPTH];

    assign busy     = 1'b0;
    assign take     = start && !busy;
    assign is_full  = (r_count == FULL_COUNT);
    assign is_empty = (r_count == '0);

    // Drop a push into a full queue and a pop on an empty one
    assign ctrl.push = take && (i_operation == OP_PUSH) && !is_full;
    assign ctrl.pop  = take && (i_operation == OP_POP) && !is_empty;

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        logic                     prev_keep;
        logic [DATA_BITS-1:0]     prev_data;
        logic [PRIORITY_BITS-1:0] prev_prio;
        logic [DATA_BITS-1:0]     next_data;
        logic [PRIORITY_BITS-1:0] next_prio;

        if (gi == 0) begin : g_head
            assign prev_keep = 1'b1;
            assign prev_data = i_item_data;
            assign prev_prio = i_item_priority;
        end else begin : g_body
            assign prev_keep = w_keep[gi-1];
            assign prev_data = w_data[gi-1];
            assign prev_prio = w_prio[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign next_data = w_data[gi];
            assign next_prio = w_prio[gi];
        end else begin : g_inner
            assign next_data = w_data[gi+1];
            assign next_prio = w_prio[gi+1];
        end

        spq_cell #(
            .DATA_BITS     (DATA_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_valid     (CNT_BITS'(gi) < r_count),
            .i_new_data  (i_item_data),
            .i_new_prio  (i_item_priority),
            .i_prev_keep (prev_keep),
            .i_prev_data (prev_data),
            .i_prev_prio (prev_prio),
            .i_next_data (next_data),
            .i_next_prio (next_prio),
            .o_keep      (w_keep[gi]),
            .o_data      (w_data[gi]),
            .o_prio      (w_prio[gi])
        );
    end

    always_comb begin
        n_count    = r_count;
        n_status   = ST_PUSHED;
        n_out_data = '0;
        n_out_prio = '0;
        if (i_operation == OP_PUSH) begin
            if (is_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (is_empty) begin
            n_status = ST_EMPTY;
        end else begin
            n_status   = ST_POPPED;
            n_out_data = w_data[0];
            n_out_prio = w_prio[0];
            n_count    = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= take;
            if (take) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload; only meaningful while the strobe is high
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status   <= n_status;
            r_out_data <= n_out_data;
            r_out_prio <= n_out_prio;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_status       = r_status;
    assign o_out_data     = r_out_data;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = r_count;

endmodule

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it with a pushed item
// and takes its content from itself, the new item or a neighbour. Uses spq_pkg.
module spq_cell #(
    parameter int DATA_BITS     = spq_pkg::DATA_BITS_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
    input  logic                     i_clk,
    input  spq_pkg::t_cell_ctrl      i_ctrl,
    input  logic                     i_valid,
    input  logic [DATA_BITS-1:0]     i_new_data,
    input  logic [PRIORITY_BITS-1:0] i_new_prio,
    input  logic                     i_prev_keep,
    input  logic [DATA_BITS-1:0]     i_prev_data,
    input  logic [PRIORITY_BITS-1:0] i_prev_prio,
    input  logic [DATA_BITS-1:0]     i_next_data,
    input  logic [PRIORITY_BITS-1:0] i_next_prio,
    output logic                     o_keep,
    output logic [DATA_BITS-1:0]     o_data,
    output logic [PRIORITY_BITS-1:0] o_prio
);
    import spq_pkg::*;

    logic [DATA_BITS-1:0]     r_data;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic [DATA_BITS-1:0]     n_data;
    logic [PRIORITY_BITS-1:0] n_prio;

    // Stay in place when the stored entry ranks at or above the new one
    assign o_keep = i_valid && (r_prio >= i_new_prio);
    assign o_data = r_data;
    assign o_prio = r_prio;

    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctrl.push && !o_keep) begin
            if (i_prev_keep) begin
                n_data = i_new_data;
                n_prio = i_new_prio;
            end else begin
                n_data = i_prev_data;
                n_prio = i_prev_prio;
            end
        end else if (i_ctrl.pop) begin
            n_data = i_next_data;
            n_prio = i_next_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

endmodule

// ===== test/spq_checker.sv =====
// Checker for the sorted priority queue: predicts every result from the taken items
// and compares it with what the unit returns. Depends on spq_pkg.
`timescale 1ns / 100ps

module spq_checker #(
    parameter int DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int DW    = spq_pkg::DATA_BITS_DEF,
    parameter int PW    = spq_pkg::PRIORITY_BITS_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             i_operation,
    input  logic [DW-1:0]    i_item_data,
    input  logic [PW-1:0]    i_item_priority,
    input  logic             o_result_valid,
    input  spq_pkg::t_status o_status,
    input  logic [DW-1:0]    o_out_data,
    input  logic [PW-1:0]    o_out_priority,
    input  logic [CW-1:0]    o_occupancy,
    output int               fail_count,
    output int               pending_count,
    output int               result_count,
    output int               full_count,
    output int               empty_count
);
    import spq_pkg::*;

    typedef struct packed {
        t_status       status;
        logic [DW-1:0] data;
        logic [PW-1:0] prio;
        logic [CW-1:0] occ;
    } t_queue_result;

    // Own copy of the queue, head at index 0
    logic [DW-1:0] slot_data [DEPTH];
    logic [PW-1:0] slot_prio [DEPTH];
    int            held;

    t_queue_result expected_results [$];

    function automatic t_queue_result apply_queue_op(input logic op,
                                                     input logic [DW-1:0] d,
                                                     input logic [PW-1:0] p);
        t_queue_result r;
        int            pos;
        r = '0;
        if (op == OP_PUSH) begin
            if (held >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // insert behind every entry of equal or higher priority
                pos = 0;
                while (pos < held && slot_prio[pos] >= p) pos++;
                for (int i = held; i > pos; i--) begin
                    slot_data[i] = slot_data[i-1];
                    slot_prio[i] = slot_prio[i-1];
                end
                slot_data[pos] = d;
                slot_prio[pos] = p;
                held++;
                r.status = ST_PUSHED;
            end
        end else if (held == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.data = slot_data[0];
            r.prio = slot_prio[0];
            for (int i = 1; i < held; i++) begin
                slot_data[i-1] = slot_data[i];
                slot_prio[i-1] = slot_prio[i];
            end
            held--;
            r.status = ST_POPPED;
        end
        r.occ = held[CW-1:0];
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] exp_val,
                                         input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val,
                     act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_queue_result exp_r;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            held = 0;
            expected_results.delete();
            fail_count    <= 0;
            pending_count <= 0;
            result_count  <= 0;
            full_count    <= 0;
            empty_count   <= 0;
        end else begin
            if (start && !busy)
                expected_results.push_back(apply_queue_op(i_operation, i_item_data,
                                                          i_item_priority));
            if (o_result_valid) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, status %0d data %0h",
                             $time, o_status, o_out_data);
                    errs++;
                end else begin
                    exp_r = expected_results.pop_front();
                    errs += field_differs("status", 32'(exp_r.status), 32'(o_status));
                    errs += field_differs("data", 32'(exp_r.data), 32'(o_out_data));
                    errs += field_differs("priority", 32'(exp_r.prio),
                                          32'(o_out_priority));
                    errs += field_differs("occupancy", 32'(exp_r.occ), 32'(o_occupancy));
                    if (exp_r.status == ST_FULL)  full_count  <= full_count + 1;
                    if (exp_r.status == ST_EMPTY) empty_count <= empty_count + 1;
                end
            end
            fail_count    <= fail_count + errs;
            pending_count <= expected_results.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Top of the priority queue testbench: clock, reset, push/pop stimulus and verdict.
// Depends on spq_pkg, sorted_priority_queue_unit and spq_checker.
`timescale 1ns / 100ps

module tb;
    import spq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int DW    = DATA_BITS_DEF;
    localparam int PW    = PRIORITY_BITS_DEF;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 850;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          i_operation;
    logic [DW-1:0] i_item_data;
    logic [PW-1:0] i_item_priority;
    logic          o_result_valid;
    t_status       o_status;
    logic [DW-1:0] o_out_data;
    logic [PW-1:0] o_out_priority;
    logic [CW-1:0] o_occupancy;

    int fail_count, pending_count, result_count, full_count, empty_count;
    int items_sent;

    sorted_priority_queue_unit #(
        .QUEUE_DEPTH   (DEPTH),
        .DATA_BITS     (DW),
        .PRIORITY_BITS (PW)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_item_data     (i_item_data),
        .i_item_priority (i_item_priority),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_out_data      (o_out_data),
        .o_out_priority  (o_out_priority),
        .o_occupancy     (o_occupancy)
    );

    spq_checker #(.DEPTH(DEPTH), .DW(DW), .PW(PW), .CW(CW)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_item_data     (i_item_data),
        .i_item_priority (i_item_priority),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_out_data      (o_out_data),
        .o_out_priority  (o_out_priority),
        .o_occupancy     (o_occupancy),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .result_count    (result_count),
        .full_count      (full_count),
        .empty_count     (empty_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

    // Hold start high until the item is taken; leave it high for a following item
    task automatic send_item(input logic op, input logic [DW-1:0] d, input logic [PW-1:0] p);
        start           <= 1'b1;
        i_operation     <= op;
        i_item_data     <= d;
        i_item_priority <= p;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            start           <= 1'b0;
            i_operation     <= 1'($urandom);
            i_item_data     <= DW'($urandom);
            i_item_priority <= PW'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    function automatic logic [PW-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return PW'($urandom_range(0, 3));   // crowd of ties
        if (r == 4) return $urandom_range(0, 1) ? '1 : '0;
        return PW'($urandom);
    endfunction

    initial begin
        int           burst_left;
        int           push_pct;
        int           phase_left;
        bit           no_gaps;
        logic [DW-1:0] junk_d;
        logic [PW-1:0] junk_p;

        items_sent      = 0;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_operation     <= OP_PUSH;
        i_item_data     <= '0;
        i_item_priority <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pop, field extremes, ties at head and tail, drain to empty
        junk_d = DW'($urandom);
        junk_p = PW'($urandom);
        send_item(OP_POP, junk_d, junk_p);
        send_item(OP_PUSH, '1, '1);
        send_item(OP_PUSH, '0, '0);
        send_item(OP_PUSH, 16'h1234, '1);
        idle_sender(2);
        send_item(OP_PUSH, 16'h0001, 8'h80);
        send_item(OP_PUSH, 16'hAAAA, '0);
        send_item(OP_PUSH, 16'h5555, 8'h80);
        send_item(OP_PUSH, 16'h7FFF, 8'h7F);
        repeat (7) send_item(OP_POP, DW'($urandom), PW'($urandom));
        send_item(OP_POP, '1, '1);
        idle_sender(3);

        // Random: alternate filling, draining and balanced phases in bursts
        burst_left = 0;
        phase_left = 0;
        push_pct   = 80;
        no_gaps    = 1'b0;
        repeat (RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 20;
                    default: push_pct = 55;
                endcase
                phase_left = $urandom_range(30, 80);
                no_gaps    = ($urandom_range(0, 3) == 0);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if (!no_gaps && $urandom_range(0, 2) != 0)
                    idle_sender($urandom_range(1, 8));
            end
            if ($urandom_range(1, 100) <= push_pct)
                send_item(OP_PUSH, DW'($urandom), pick_priority());
            else
                send_item(OP_POP, DW'($urandom), PW'($urandom));
            burst_left--;
            phase_left--;
        end
        idle_sender(1);

        // Drain outstanding results, then idle before the verdict
        begin
            int waited;
            waited = 0;
            while (pending_count != 0 && waited < 1000) begin
                @(posedge i_clk);
                waited++;
            end
        end
        repeat (4) @(posedge i_clk);

        $display("Sent %0d push/pop items, checked %0d results", items_sent, result_count);
        $display("Pushes refused when full: %0d, pops on an empty queue: %0d",
                 full_count, empty_count);
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
